// ----- hw/rtl/ptsb_pkg.sv -----
`timescale 1ns / 1ps

package ptsb_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int SLOT_COUNT_MAX = 16;

    localparam int OP_W     = 3;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_CREATE  = 3'd1;
    localparam logic [OP_W-1:0] OP_START   = 3'd2;
    localparam logic [OP_W-1:0] OP_RELOAD  = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd4;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd5;
    localparam logic [OP_W-1:0] OP_PROCESS = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [COUNT_W-1:0] reload_value;
        logic [COUNT_W-1:0] down_count;
        logic               running;
        logic               due_mark;
        logic               always_fire;
        logic               in_use;
    } slot_t;

    // control for the update unit at the head of the ring
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic               hit;
        logic               found;
        logic [COUNT_W-1:0] interval;
    } head_ctl_t;

    typedef struct packed {
        logic take;
        logic report;
    } head_flags_t;

endpackage

// ----- hw/rtl/periodic_timer_slot_bank_unit.sv -----
`timescale 1ns / 1ps
// Channel   Signals                               Direction
// req       req_valid, req_stall; operation,      in
//           slot, interval
// rsp       rsp_valid, rsp_stall; status,         out
//           slot_out, fired, last
//
// Slot state sits in a ring of SLOT_COUNT cells that, during a sweep, rotates one
// place per cycle through an update unit at its head; every operation is one full turn.
// The final word is loaded into rsp from the done state that follows the sweep,
// and req_stall stays high until that load, so the bank takes no new request
// while an operation is still under way.
// Process holds the ring while a reported word waits on a stalled rsp.
// Reset clears every slot and the control state at once; no clearing pass.

module periodic_timer_slot_bank_unit
#(
    parameter int SLOT_COUNT = ptsb_pkg::SLOT_COUNT_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [ptsb_pkg::OP_W-1:0]       operation,
    input  logic [ptsb_pkg::SLOT_W-1:0]     slot,
    input  logic [ptsb_pkg::COUNT_W-1:0]    interval,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [ptsb_pkg::STATUS_W-1:0]   status,
    output logic [ptsb_pkg::SLOT_W-1:0]     slot_out,
    output logic                            fired,
    output logic                            last
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(SLOT_COUNT - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic [ptsb_pkg::OP_W-1:0]    op_reg;
    logic [ptsb_pkg::SLOT_W-1:0]  slot_reg;
    logic [ptsb_pkg::COUNT_W-1:0] interval_reg;
    logic [IDX_W-1:0]             step_reg;
    logic [IDX_W-1:0]             step_next;
    logic                         found_reg;
    logic                         found_next;
    logic [IDX_W-1:0]             found_idx_reg;
    logic [IDX_W-1:0]             found_idx_next;
    logic                         pend_valid_reg;
    logic                         pend_valid_next;
    logic [IDX_W-1:0]             pend_slot_reg;
    logic [IDX_W-1:0]             pend_slot_next;

    logic                            out_valid_reg;
    logic [ptsb_pkg::STATUS_W-1:0]   status_reg;
    logic [ptsb_pkg::SLOT_W-1:0]     slot_out_reg;
    logic                            fired_reg;
    logic                            last_reg;

    logic                            accept;
    logic                            out_free;
    logic                            advance;
    logic                            shift_en;
    logic                            sweep_push;
    logic                            done_push;
    logic                            out_load;
    logic [ptsb_pkg::STATUS_W-1:0]   load_status;
    logic [ptsb_pkg::SLOT_W-1:0]     load_slot;
    logic                            load_fired;
    logic                            load_last;
    logic                            range_op;
    logic                            in_range;

    ptsb_pkg::slot_t       cell_q [SLOT_COUNT];
    ptsb_pkg::slot_t       cell_d [SLOT_COUNT];
    ptsb_pkg::slot_t       head_upd;
    ptsb_pkg::head_ctl_t   head_ctl;
    ptsb_pkg::head_flags_t head_flags;

    assign accept   = req_valid && !req_stall;
    assign out_free = !out_valid_reg || !rsp_stall;
    assign in_range = {1'b0, slot_reg} < (ptsb_pkg::SLOT_W + 1)'(SLOT_COUNT);

    // ring of slot cells, head feeds the last cell
    genvar gi;
    generate
        for (gi = 0; gi < SLOT_COUNT; gi++)
        begin : g_cell
            if (gi == SLOT_COUNT - 1)
            begin : g_tail
                assign cell_d[gi] = head_upd;
            end
            else
            begin : g_mid
                assign cell_d[gi] = cell_q[gi+1];
            end
            ptsb_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .d        (cell_d[gi]),
                .q        (cell_q[gi])
            );
        end
    endgenerate

    assign head_ctl.op       = op_reg;
    assign head_ctl.hit      = (ptsb_pkg::SLOT_W'(step_reg) == slot_reg);
    assign head_ctl.found    = found_reg;
    assign head_ctl.interval = interval_reg;

    ptsb_head u_head
    (
        .ctl   (head_ctl),
        .cur   (cell_q[0]),
        .upd   (head_upd),
        .flags (head_flags)
    );

    // a reported slot with one already pending needs room in rsp
    assign sweep_push = (state_reg == S_SWEEP) && head_flags.report && pend_valid_reg
                        && out_free;
    assign advance    = (state_reg == S_SWEEP)
                        && !(head_flags.report && pend_valid_reg && !out_free);
    assign shift_en   = advance;
    assign done_push  = (state_reg == S_DONE) && out_free;
    assign out_load   = sweep_push || done_push;
    assign req_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        unique case (op_reg) inside
            ptsb_pkg::OP_START, ptsb_pkg::OP_RELOAD,
            ptsb_pkg::OP_STOP, ptsb_pkg::OP_DELETE:
            begin
                range_op = 1'b1;
            end
            default:
            begin
                range_op = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        load_status = ptsb_pkg::ST_OK;
        load_slot   = '0;
        load_fired  = 1'b0;
        load_last   = 1'b1;
        if (sweep_push)
        begin
            load_slot  = ptsb_pkg::SLOT_W'(pend_slot_reg);
            load_fired = 1'b1;
            load_last  = 1'b0;
        end
        else if (range_op && !in_range)
        begin
            load_status = ptsb_pkg::ST_RANGE;
        end
        else if (op_reg == ptsb_pkg::OP_CREATE)
        begin
            if (found_reg)
            begin
                load_slot = ptsb_pkg::SLOT_W'(found_idx_reg);
            end
            else
            begin
                load_status = ptsb_pkg::ST_FULL;
            end
        end
        else if (pend_valid_reg)
        begin
            load_slot  = ptsb_pkg::SLOT_W'(pend_slot_reg);
            load_fired = 1'b1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next      = S_SWEEP;
                    step_next       = '0;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                end
            end
            S_SWEEP:
            begin
                if (advance)
                begin
                    if (head_flags.take)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = step_reg;
                    end
                    if (head_flags.report)
                    begin
                        pend_valid_next = 1'b1;
                        pend_slot_next  = step_reg;
                    end
                    if (step_reg == LAST_STEP)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        step_next = step_reg + IDX_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_idx_reg <= found_idx_next;
        pend_slot_reg <= pend_slot_next;
        if (accept)
        begin
            op_reg       <= operation;
            slot_reg     <= slot;
            interval_reg <= interval;
        end
        if (out_load)
        begin
            status_reg   <= load_status;
            slot_out_reg <= load_slot;
            fired_reg    <= load_fired;
            last_reg     <= load_last;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot_out  = slot_out_reg;
    assign fired     = fired_reg;
    assign last      = last_reg;

endmodule

// ----- hw/rtl/ptsb_cell.sv -----
`timescale 1ns / 1ps

module ptsb_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  ptsb_pkg::slot_t d,
    output ptsb_pkg::slot_t q
);

    ptsb_pkg::slot_t slot_reg;
    ptsb_pkg::slot_t slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (shift_en)
        begin
            slot_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign q = slot_reg;

endmodule

// ----- hw/rtl/ptsb_head.sv -----
`timescale 1ns / 1ps

module ptsb_head
(
    input  ptsb_pkg::head_ctl_t   ctl,
    input  ptsb_pkg::slot_t       cur,
    output ptsb_pkg::slot_t       upd,
    output ptsb_pkg::head_flags_t flags
);

    logic [ptsb_pkg::COUNT_W-1:0] count_dec;

    assign count_dec = cur.down_count - ptsb_pkg::COUNT_W'(1);

    always_comb
    begin
        upd          = cur;
        flags.take   = 1'b0;
        flags.report = 1'b0;
        unique case (ctl.op)
            ptsb_pkg::OP_TICK:
            begin
                if (cur.running && (cur.down_count != '0))
                begin
                    if (count_dec == '0)
                    begin
                        upd.down_count = cur.reload_value;
                        upd.due_mark   = 1'b1;
                    end
                    else
                    begin
                        upd.down_count = count_dec;
                    end
                end
            end
            ptsb_pkg::OP_CREATE:
            begin
                // first free slot seen in the sweep is the lowest index
                if (!cur.in_use && !ctl.found)
                begin
                    flags.take       = 1'b1;
                    upd.reload_value = ctl.interval;
                    upd.down_count   = ctl.interval;
                    upd.due_mark     = 1'b0;
                    upd.running      = 1'b0;
                    upd.always_fire  = (ctl.interval == '0);
                    upd.in_use       = 1'b1;
                end
            end
            ptsb_pkg::OP_START:
            begin
                if (ctl.hit)
                begin
                    upd.running = 1'b1;
                end
            end
            ptsb_pkg::OP_RELOAD:
            begin
                if (ctl.hit)
                begin
                    upd.down_count = cur.reload_value;
                end
            end
            ptsb_pkg::OP_STOP:
            begin
                if (ctl.hit)
                begin
                    upd.running = 1'b0;
                end
            end
            ptsb_pkg::OP_DELETE:
            begin
                if (ctl.hit)
                begin
                    upd = '0;
                end
            end
            ptsb_pkg::OP_PROCESS:
            begin
                flags.report = cur.due_mark || cur.always_fire;
                upd.due_mark = 1'b0;
            end
            default:
            begin
                upd = cur;
            end
        endcase
    end

endmodule

// ----- hw/rtl/ptsb_checker.sv -----
`timescale 1ns / 1ps

module ptsb_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_stall,
    input logic                            rsp_valid,
    input logic                            rsp_stall,
    input logic [ptsb_pkg::STATUS_W-1:0]   status,
    input logic [ptsb_pkg::SLOT_W-1:0]     slot_out,
    input logic                            fired,
    input logic                            last
);

    // an accepted word keeps the bank busy for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("req_stall low right after an accepted word");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(slot_out)
            && $stable(fired) && $stable(last))
        else $error("stalled rsp word changed");

    // only a process report may be followed by more words
    a_unfired_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !fired |-> last)
        else $error("unfired rsp word not marked last");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ptsb_pkg::ST_OK) |-> last && !fired && (slot_out == '0))
        else $error("error word carries a slot or a fired mark");

endmodule

bind periodic_timer_slot_bank_unit ptsb_checker u_ptsb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .slot_out  (slot_out),
    .fired     (fired),
    .last      (last)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int SLOTS = ptsb_pkg::SLOT_COUNT_DEF;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 80;
    localparam logic [ptsb_pkg::OP_W-1:0] OP_SPARE = 3'd7;

    typedef struct packed {
        logic [ptsb_pkg::STATUS_W-1:0] status;
        logic [ptsb_pkg::SLOT_W-1:0]   slot_out;
        logic                          fired;
        logic                          last;
    } timer_word_t;

    class slot_bank_mirror;
        logic [ptsb_pkg::COUNT_W-1:0] reload_val [SLOTS];
        logic [ptsb_pkg::COUNT_W-1:0] count_left [SLOTS];
        logic                         run_on     [SLOTS];
        logic                         due        [SLOTS];
        logic                         every_pass [SLOTS];
        logic                         taken      [SLOTS];
        timer_word_t                  pending_words [$];
        int                           errors;

        function new();
            errors = 0;
            for (int i = 0; i < SLOTS; i++)
                free_slot(i);
        endfunction

        function void free_slot(int i);
            reload_val[i] = '0;
            count_left[i] = '0;
            run_on[i]     = 1'b0;
            due[i]        = 1'b0;
            every_pass[i] = 1'b0;
            taken[i]      = 1'b0;
        endfunction

        function void push_word(logic [ptsb_pkg::STATUS_W-1:0] st, int idx, logic hit,
                                logic fin);
            timer_word_t w;
            w.status   = st;
            w.slot_out = idx[ptsb_pkg::SLOT_W-1:0];
            w.fired    = hit;
            w.last     = fin;
            pending_words.push_back(w);
        endfunction

        function void note_request(logic [ptsb_pkg::OP_W-1:0] op,
                                   logic [ptsb_pkg::SLOT_W-1:0] idx,
                                   logic [ptsb_pkg::COUNT_W-1:0] ivl);
            int n;
            int free_idx;
            n = 0;
            free_idx = -1;
            case (op)
                ptsb_pkg::OP_TICK:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (run_on[i] && count_left[i] != '0)
                        begin
                            count_left[i] = count_left[i] - 1'b1;
                            if (count_left[i] == '0)
                            begin
                                count_left[i] = reload_val[i];
                                due[i] = 1'b1;
                            end
                        end
                    push_word(ptsb_pkg::ST_OK, 0, 1'b0, 1'b1);
                end
                ptsb_pkg::OP_CREATE:
                begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!taken[i])
                            free_idx = i;
                    if (free_idx < 0)
                        push_word(ptsb_pkg::ST_FULL, 0, 1'b0, 1'b1);
                    else
                    begin
                        reload_val[free_idx] = ivl;
                        count_left[free_idx] = ivl;
                        due[free_idx]        = 1'b0;
                        run_on[free_idx]     = 1'b0;
                        every_pass[free_idx] = (ivl == '0);
                        taken[free_idx]      = 1'b1;
                        push_word(ptsb_pkg::ST_OK, free_idx, 1'b0, 1'b1);
                    end
                end
                ptsb_pkg::OP_START, ptsb_pkg::OP_RELOAD, ptsb_pkg::OP_STOP,
                ptsb_pkg::OP_DELETE:
                begin
                    if (idx >= SLOTS)
                        push_word(ptsb_pkg::ST_RANGE, 0, 1'b0, 1'b1);
                    else
                    begin
                        if (op == ptsb_pkg::OP_START)
                            run_on[idx] = 1'b1;
                        else if (op == ptsb_pkg::OP_RELOAD)
                            count_left[idx] = reload_val[idx];
                        else if (op == ptsb_pkg::OP_STOP)
                            run_on[idx] = 1'b0;
                        else
                            free_slot(idx);
                        push_word(ptsb_pkg::ST_OK, 0, 1'b0, 1'b1);
                    end
                end
                ptsb_pkg::OP_PROCESS:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (due[i] || every_pass[i])
                        begin
                            push_word(ptsb_pkg::ST_OK, i, 1'b1, 1'b0);
                            due[i] = 1'b0;
                            n++;
                        end
                    if (n == 0)
                        push_word(ptsb_pkg::ST_OK, 0, 1'b0, 1'b1);
                    else
                        pending_words[pending_words.size() - 1].last = 1'b1;
                end
                default:
                    push_word(ptsb_pkg::ST_OK, 0, 1'b0, 1'b1);
            endcase
        endfunction

        task report(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            errors++;
        endtask

        task check_word(timer_word_t got);
            timer_word_t want;
            if (pending_words.size() == 0)
            begin
                report($sformatf("unexpected word status %0d slot %0d fired %0d last %0d",
                                 got.status, got.slot_out, got.fired, got.last));
                return;
            end
            want = pending_words.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.slot_out !== want.slot_out)
                report($sformatf("slot_out %0d, want %0d", got.slot_out, want.slot_out));
            if (got.fired !== want.fired)
                report($sformatf("fired %0d, want %0d", got.fired, want.fired));
            if (got.last !== want.last)
                report($sformatf("last %0d, want %0d", got.last, want.last));
        endtask
    endclass

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_stall;
    logic [ptsb_pkg::OP_W-1:0]     operation = ptsb_pkg::OP_TICK;
    logic [ptsb_pkg::SLOT_W-1:0]   slot      = '0;
    logic [ptsb_pkg::COUNT_W-1:0]  interval  = '0;
    logic                          rsp_valid;
    logic                          rsp_stall = 1'b0;
    logic [ptsb_pkg::STATUS_W-1:0] status;
    logic [ptsb_pkg::SLOT_W-1:0]   slot_out;
    logic                          fired;
    logic                          last;

    timer_word_t     rsp_word;
    slot_bank_mirror book = new();
    int              send_idle = 0;
    int              recv_idle = 0;
    int              hold_left = 0;
    logic            hold_go = 1'b0;
    logic            hold_taken = 1'b0;
    int              quiet = 0;

    assign rsp_word = {status, slot_out, fired, last};

    periodic_timer_slot_bank_unit #(.SLOT_COUNT(SLOTS)) DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .operation (operation),
        .slot      (slot),
        .interval  (interval),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .slot_out  (slot_out),
        .fired     (fired),
        .last      (last)
    );

    always #5 clk = ~clk;

    // receiver: check accepted words, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            book.check_word(rsp_word);
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_go && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            rsp_stall  <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic send_word(logic [ptsb_pkg::OP_W-1:0] op,
                             logic [ptsb_pkg::SLOT_W-1:0] idx,
                             logic [ptsb_pkg::COUNT_W-1:0] ivl);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        slot      <= idx;
        interval  <= ivl;
        do
            @(posedge clk);
        while (req_stall);
        book.note_request(op, idx, ivl);
    endtask

    task automatic random_request();
        int                           pick;
        int                           sel;
        logic [ptsb_pkg::OP_W-1:0]    op;
        logic [ptsb_pkg::SLOT_W-1:0]  idx;
        logic [ptsb_pkg::COUNT_W-1:0] ivl;
        pick = $urandom_range(99);
        idx  = ptsb_pkg::SLOT_W'($urandom_range(15));
        ivl  = $urandom;
        if (pick < 30)
            send_word(ptsb_pkg::OP_TICK, idx, ivl);
        else if (pick < 43)
        begin
            // mostly short periods so slots actually fire
            sel = $urandom_range(19);
            if (sel < 12)
                ivl = $urandom_range(6, 1);
            else if (sel < 15)
                ivl = '0;
            send_word(ptsb_pkg::OP_CREATE, idx, ivl);
        end
        else if (pick < 80)
        begin
            if (pick < 58)
                op = ptsb_pkg::OP_START;
            else if (pick < 64)
                op = ptsb_pkg::OP_RELOAD;
            else if (pick < 71)
                op = ptsb_pkg::OP_STOP;
            else
                op = ptsb_pkg::OP_DELETE;
            if ($urandom_range(9) != 0)
                idx = ptsb_pkg::SLOT_W'($urandom_range(SLOTS - 1));
            send_word(op, idx, ivl);
        end
        else if (pick < 97)
            send_word(ptsb_pkg::OP_PROCESS, idx, ivl);
        else
            send_word(OP_SPARE, idx, ivl);
    endtask

    initial
    begin
        send_idle = 7;
        recv_idle <= 51;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(ptsb_pkg::OP_PROCESS, 4'd9, 32'h0);
        send_word(ptsb_pkg::OP_CREATE, 4'd15, 32'h0);
        send_word(ptsb_pkg::OP_CREATE, 4'd0, 32'd1);
        send_word(ptsb_pkg::OP_CREATE, 4'd7, 32'hFFFF_FFFF);
        send_word(ptsb_pkg::OP_START, 4'd1, 32'hFFFF_FFFF);
        send_word(ptsb_pkg::OP_START, 4'd2, 32'h0);
        send_word(ptsb_pkg::OP_TICK, 4'd15, 32'hFFFF_FFFF);
        send_word(ptsb_pkg::OP_PROCESS, 4'd0, 32'h0);
        send_word(ptsb_pkg::OP_RELOAD, 4'd2, 32'h5A5A_A5A5);
        send_word(ptsb_pkg::OP_STOP, 4'd1, 32'h0);
        send_word(ptsb_pkg::OP_START, 4'd15, 32'h0);
        send_word(ptsb_pkg::OP_RELOAD, 4'd8, 32'h0);
        send_word(ptsb_pkg::OP_STOP, 4'd12, 32'h0);
        send_word(ptsb_pkg::OP_DELETE, 4'd9, 32'h0);
        send_word(OP_SPARE, 4'd3, 32'h1234_5678);
        // fill the bank, then overflow it
        repeat (5)
            send_word(ptsb_pkg::OP_CREATE, 4'd0, $urandom_range(4, 1));
        send_word(ptsb_pkg::OP_CREATE, 4'd0, 32'd3);
        send_word(ptsb_pkg::OP_DELETE, 4'd0, 32'h0);
        send_word(ptsb_pkg::OP_START, 4'd0, 32'h0);
        send_word(ptsb_pkg::OP_PROCESS, 4'd0, 32'h0);
        send_word(ptsb_pkg::OP_DELETE, 4'd2, 32'h0);

        repeat (55)
            random_request();

        send_idle = 51;
        recv_idle <= 7;
        repeat (75)
            random_request();

        // long receiver hold while the sender keeps offering
        send_idle = 0;
        recv_idle <= 0;
        hold_go <= 1'b1;
        repeat (75)
            random_request();
        req_valid <= 1'b0;

        while (book.pending_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (book.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/ptsb_pkg.sv
hw/rtl/ptsb_cell.sv
hw/rtl/ptsb_head.sv
hw/rtl/periodic_timer_slot_bank_unit.sv
hw/rtl/ptsb_checker.sv
tb/sv/testbench.sv
